// ===== rtl/iisb_pkg.sv =====
package iisb_pkg;

    localparam int IISB_IW = 7;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_POS = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_READOUT = 1'b1;

    typedef struct packed {
        logic               ins;
        logic               rot;
        logic [IISB_IW-1:0] pos;
        logic [IISB_IW-1:0] cnt;
    } iisb_ctrl_t;

endpackage

// ===== rtl/iisb_cell.sv =====
module iisb_cell
    import iisb_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                         aclk,
    input  iisb_ctrl_t                   ctrl,
    input  logic signed [DATA_WIDTH-1:0] ins_value,
    input  logic signed [DATA_WIDTH-1:0] prev_data,
    input  logic signed [DATA_WIDTH-1:0] next_data,
    input  logic signed [DATA_WIDTH-1:0] head_data,
    output logic signed [DATA_WIDTH-1:0] data
);

    localparam logic [IISB_IW-1:0] MY_IDX  = IISB_IW'(IDX);
    localparam logic [IISB_IW-1:0] MY_NEXT = IISB_IW'(IDX + 1);

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (MY_IDX == ctrl.pos) begin
                data_next = ins_value;
            end else if (MY_IDX > ctrl.pos) begin
                data_next = prev_data;
            end
        end else if (ctrl.rot) begin
            // rotate the occupied part of the row toward the head
            if (MY_NEXT < ctrl.cnt) begin
                data_next = next_data;
            end else if (MY_NEXT == ctrl.cnt) begin
                data_next = head_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/indexed_insert_sequence_buffer.sv =====
// channel | direction | ports                                              | handshake
// s_      | in        | s_command, s_value, s_position                      | s_valid / s_ready
// m_      | out       | m_status, m_element, m_element_valid, m_last, m_length | m_valid / m_ready
// Insert: one status word; with a valid position and room, the cell row shifts in the
// cycle it is accepted. Readout: count words from the read state entered on acceptance,
// one per cycle at best, paced by m_ready; each word rotates the row one place, and the
// input is held off until the last word is issued. Empty readout gives one status word.
// Synchronous active-low reset empties the buffer; cell contents are not reset.
module indexed_insert_sequence_buffer
    import iisb_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [31:0] s_value,
    input  logic [5:0]         s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_element,
    output logic               m_element_valid,
    output logic               m_last,
    output logic [5:0]         m_length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                         state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         m_valid_reg, m_valid_next;
    logic [1:0]                   m_status_reg, m_status_next;
    logic signed [31:0]           m_element_reg, m_element_next;
    logic                         m_element_valid_reg, m_element_valid_next;
    logic                         m_last_reg, m_last_next;
    logic [5:0]                   m_length_reg, m_length_next;

    logic                         out_free;
    logic                         accept;
    logic                         rd_last;
    logic [IISB_IW-1:0]           pos_w, cnt_w;
    logic signed [DATA_WIDTH-1:0] ins_value;
    logic signed [DATA_WIDTH-1:0] cell_data [CAPACITY];
    iisb_ctrl_t                   ctrl;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign pos_w     = IISB_IW'(s_position);
    assign cnt_w     = IISB_IW'(count_reg);
    assign ins_value = DATA_WIDTH'(s_value);
    assign rd_last   = CNT_W'(rd_idx_reg + 1'b1) == count_reg;

    always_comb begin
        state_next           = state_reg;
        count_next           = count_reg;
        rd_idx_next          = rd_idx_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        m_status_next        = m_status_reg;
        m_element_next       = m_element_reg;
        m_element_valid_next = m_element_valid_reg;
        m_last_next          = m_last_reg;
        m_length_next        = m_length_reg;
        ctrl.ins             = 1'b0;
        ctrl.rot             = 1'b0;
        ctrl.pos             = pos_w;
        ctrl.cnt             = cnt_w;

        if (accept) begin
            m_valid_next         = 1'b1;
            m_element_next       = '0;
            m_element_valid_next = 1'b0;
            m_last_next          = 1'b1;
            m_status_next        = STATUS_OK;
            m_length_next        = 6'(count_reg);
            if (s_command == CMD_INSERT) begin
                if (pos_w > cnt_w) begin
                    m_status_next = STATUS_BAD_POS;
                end else if (cnt_w == IISB_IW'(CAPACITY)) begin
                    m_status_next = STATUS_FULL;
                end else begin
                    ctrl.ins      = 1'b1;
                    count_next    = CNT_W'(count_reg + 1'b1);
                    m_length_next = 6'(count_next);
                end
            end else if (count_reg != '0) begin
                m_valid_next = 1'b0;
                state_next   = ST_READ;
                rd_idx_next  = '0;
            end
        end else if (state_reg == ST_READ && out_free) begin
            ctrl.rot             = 1'b1;
            m_valid_next         = 1'b1;
            m_status_next        = STATUS_OK;
            m_element_next       = 32'(cell_data[0]);
            m_element_valid_next = 1'b1;
            m_last_next          = rd_last;
            m_length_next        = 6'(count_reg);
            rd_idx_next          = CNT_W'(rd_idx_reg + 1'b1);
            if (rd_last) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg        <= m_status_next;
        m_element_reg       <= m_element_next;
        m_element_valid_reg <= m_element_valid_next;
        m_last_reg          <= m_last_next;
        m_length_reg        <= m_length_next;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] prev_d;
        logic signed [DATA_WIDTH-1:0] next_d;

        if (i == 0) begin : g_first
            assign prev_d = ins_value;
        end else begin : g_mid
            assign prev_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_d = cell_data[0];
        end else begin : g_inner
            assign next_d = cell_data[i+1];
        end

        iisb_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .IDX       (i)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .ins_value(ins_value),
            .prev_data(prev_d),
            .next_data(next_d),
            .head_data(cell_data[0]),
            .data     (cell_data[i])
        );
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_element       = m_element_reg;
    assign m_element_valid = m_element_valid_reg;
    assign m_last          = m_last_reg;
    assign m_length        = m_length_reg;

endmodule

// ===== rtl/iisb_checker.sv =====
module iisb_checker
    import iisb_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic signed [31:0] m_element,
    input logic               m_element_valid,
    input logic               m_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_element) && $stable(m_last))
        else $error("output word changed while stalled");

    // input taken only when the output slot frees up
    a_ready_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid || m_ready)
        else $error("input ready while output stalled");

    // status words carry no element and close their command
    a_status_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_element_valid |-> m_last && m_element == 32'sd0)
        else $error("malformed status word");

    a_err_no_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> !m_element_valid)
        else $error("error status on element word");

    // input stays blocked in the middle of a readout stream
    a_stream_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_element_valid && !m_last |-> !s_ready)
        else $error("input ready during readout");

endmodule

bind indexed_insert_sequence_buffer iisb_checker u_iisb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_element      (m_element),
    .m_element_valid(m_element_valid),
    .m_last         (m_last)
);
